### hdl/tcrs_pkg.sv
package tcrs_pkg;

  // Fixed-point formats of the ports and CORDIC sizes
  localparam int FractionBits    = 16;
  localparam int CordicStagesDef = 20;
  localparam int AtanLen         = 32;
  localparam int InW             = 25;
  localparam int OutW            = 27;

  // Internal widths
  localparam int SqW    = 2 * InW;       // b^2 and M^2
  localparam int NumW   = SqW + 5;       // 27 * M^2
  localparam int QuoW   = 61;            // quotient of the Q60 divide
  localparam int RadW   = 62;            // radicand of the square roots
  localparam int RootW  = 31;            // square root result
  localparam int RemW   = RootW + 2;     // square root partial remainder
  localparam int RadW2  = 56;            // b * 2/sqrt3 product
  localparam int RW     = 26;            // scaled radius
  localparam int CW     = 34;            // CORDIC datapath
  localparam int CosW   = 36;            // cosine terms
  localparam int HpW    = 65;            // sin * sqrt3/2 product
  localparam int PrW    = 63;            // radius * cosine product

  // Constants, Q30 unless noted
  localparam logic [32:0] PiQ30          = 33'd3373259426;
  localparam logic [29:0] GainInvQ30     = 30'd652032874;
  localparam logic [29:0] HalfSqrt3Q30   = 30'd929887697;
  localparam logic [30:0] TwoOverSqrt3   = 31'd1239850262;
  localparam logic [31:0] Recip3         = 32'd2863311531; // ceil(2^33 / 3)
  localparam logic [InW-1:0] MassReset   = 25'd65536;
  localparam logic signed [PrW-1:0] HalfUlp = 63'sd536870912;
  localparam logic signed [PrW-1:0] OutMax  = 63'sd67108863;
  localparam logic signed [PrW-1:0] OutMin  = -63'sd67108864;

  // Arctangent of 2^-idx, Q30
  function automatic logic [CW-1:0] atan_q30(input int idx);
    logic [CW-1:0] v;
    case (idx)
      0:  v = 34'h03243F6A8;
      1:  v = 34'h01DAC6705;
      2:  v = 34'h00FADBAFC;
      3:  v = 34'h007F56EA6;
      4:  v = 34'h003FEAB76;
      5:  v = 34'h001FFD55B;
      6:  v = 34'h000FFFAAA;
      7:  v = 34'h0007FFF55;
      8:  v = 34'h0003FFFEA;
      9:  v = 34'h0001FFFFD;
      10: v = 34'h0000FFFFF;
      11: v = 34'h00007FFFF;
      12: v = 34'h00003FFFF;
      13: v = 34'h00001FFFF;
      14: v = 34'h00000FFFF;
      15: v = 34'h000007FFF;
      16: v = 34'h000003FFF;
      17: v = 34'h000001FFF;
      18: v = 34'h000000FFF;
      19: v = 34'h0000007FF;
      20: v = 34'h0000003FF;
      21: v = 34'h0000001FF;
      22: v = 34'h0000000FF;
      23: v = 34'h00000007F;
      24: v = 34'h00000003F;
      25: v = 34'h00000001F;
      26: v = 34'h00000000F;
      27: v = 34'h000000008;
      28: v = 34'h000000004;
      29: v = 34'h000000002;
      30: v = 34'h000000001;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

### hdl/tcrs_div_cell.sv
module tcrs_div_cell import tcrs_pkg::*; #(
  parameter int FIRST  = 0,
  parameter int SIDE_W = 1
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  logic              valid_i,
  input  logic [SIDE_W-1:0] side_i,
  input  logic [SqW-1:0]    den_i,
  input  logic [SqW-1:0]    rem_i,
  input  logic [QuoW-1:0]   quo_i,
  output logic              valid_o,
  output logic [SIDE_W-1:0] side_o,
  output logic [SqW-1:0]    den_o,
  output logic [SqW-1:0]    rem_o,
  output logic [QuoW-1:0]   quo_o
);

  logic [SqW:0] rem_sh, diff;
  logic         ge;

  // Shift the remainder (except in the first cell) and try one subtraction
  always_comb begin
    rem_sh = (FIRST != 0) ? {1'b0, rem_i} : {rem_i, 1'b0};
    ge     = rem_sh >= {1'b0, den_i};
    diff   = rem_sh - {1'b0, den_i};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_o <= 1'b0;
    end else if (en_i) begin
      valid_o <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      side_o <= side_i;
      den_o  <= den_i;
      rem_o  <= ge ? diff[SqW-1:0] : rem_sh[SqW-1:0];
      quo_o  <= {quo_i[QuoW-2:0], ge};
    end
  end

endmodule

### hdl/tcrs_sqrt_cell.sv
module tcrs_sqrt_cell import tcrs_pkg::*; #(
  parameter int SIDE_W = 1
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  logic              valid_i,
  input  logic [SIDE_W-1:0] side_i,
  input  logic [RadW-1:0]   rad_i,
  input  logic [RemW-1:0]   rem_i,
  input  logic [RootW-1:0]  root_i,
  output logic              valid_o,
  output logic [SIDE_W-1:0] side_o,
  output logic [RadW-1:0]   rad_o,
  output logic [RemW-1:0]   rem_o,
  output logic [RootW-1:0]  root_o
);

  logic [RemW+1:0] rem_sh, trial, diff;
  logic            ge;

  // Bring down two radicand bits and test the next root bit
  always_comb begin
    rem_sh = {rem_i, rad_i[RadW-1 -: 2]};
    trial  = {2'b00, root_i, 2'b01};
    ge     = rem_sh >= trial;
    diff   = rem_sh - trial;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_o <= 1'b0;
    end else if (en_i) begin
      valid_o <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      side_o <= side_i;
      rad_o  <= {rad_i[RadW-3:0], 2'b00};
      rem_o  <= ge ? diff[RemW-1:0] : rem_sh[RemW-1:0];
      root_o <= {root_i[RootW-2:0], ge};
    end
  end

endmodule

### hdl/tcrs_cordic_cell.sv
module tcrs_cordic_cell import tcrs_pkg::*; #(
  parameter int IDX    = 0,
  parameter int ROTATE = 0,
  parameter int SIDE_W = 1
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 en_i,
  input  logic                 valid_i,
  input  logic [SIDE_W-1:0]    side_i,
  input  logic signed [CW-1:0] x_i,
  input  logic signed [CW-1:0] y_i,
  input  logic signed [CW-1:0] z_i,
  output logic                 valid_o,
  output logic [SIDE_W-1:0]    side_o,
  output logic signed [CW-1:0] x_o,
  output logic signed [CW-1:0] y_o,
  output logic signed [CW-1:0] z_o
);

  logic signed [CW-1:0] xs, ys, at, x_d, y_d, z_d;
  logic                 pos;

  // One micro-rotation; direction from y (vectoring) or z (rotation)
  always_comb begin
    xs  = x_i >>> IDX;
    ys  = y_i >>> IDX;
    at  = $signed(atan_q30(IDX));
    pos = (ROTATE != 0) ? !z_i[CW-1] : !y_i[CW-1];
    if (ROTATE != 0) begin
      if (pos) begin
        x_d = x_i - ys;
        y_d = y_i + xs;
        z_d = z_i - at;
      end else begin
        x_d = x_i + ys;
        y_d = y_i - xs;
        z_d = z_i + at;
      end
    end else begin
      if (pos) begin
        x_d = x_i + ys;
        y_d = y_i - xs;
        z_d = z_i + at;
      end else begin
        x_d = x_i - ys;
        y_d = y_i + xs;
        z_d = z_i - at;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_o <= 1'b0;
    end else if (en_i) begin
      valid_o <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      side_o <= side_i;
      x_o    <= x_d;
      y_o    <= y_d;
      z_o    <= z_d;
    end
  end

endmodule

### hdl/trig_cubic_root_solver.sv
// Trigonometric cubic root solver.
// Solves x^3 - b^2 x + 2 b^2 M = 0 for each coefficient b and returns the
// three real roots (k = 0, 1, 2) and the largest of them, signed Q10.16.
// Input channel: in_valid_i / in_ready_o with coefficient_b_i (unsigned Q9.16).
// Output channel: out_valid_o / out_ready_i with the roots and in_domain_o.
// Config channel: cfg_valid_i / cfg_ready_o with mass_i; always ready. Write
// M only while no transfer is in flight.
// Throughput: one transfer per cycle unless the output stalls. The pipeline is
// a chain of cells: 61 divider cells, two chains of 31 square root cells,
// two CORDIC chains and the stages A, B, C, T and P1 to P4.
// When b is zero or b^2 < 27 M^2 the roots are zero and in_domain_o is low.
// Reset clears all valid bits and loads M = 1.0; no results are pending.
// When the receiver stalls the result is held in the output register; the
// pipeline keeps taking transfers until its final stage is occupied, then
// in_ready_o drops and everything holds in place.
module trig_cubic_root_solver import tcrs_pkg::*; #(
  parameter int CORDIC_STAGES = CordicStagesDef
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_valid_i,
  output logic                   cfg_ready_o,
  input  logic [InW-1:0]         mass_i,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  logic [InW-1:0]         coefficient_b_i,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output logic signed [OutW-1:0] root_first_o,
  output logic signed [OutW-1:0] root_second_o,
  output logic signed [OutW-1:0] root_third_o,
  output logic signed [OutW-1:0] largest_root_o,
  output logic                   in_domain_o
);

  localparam int Nst = (CORDIC_STAGES < AtanLen) ? CORDIC_STAGES : AtanLen;
  localparam int SdW = RW + 1;          // {domain, radius}
  localparam int ScW = RootW + SdW;     // {c, domain, radius}

  logic en;
  logic lv_q, ov_q;

  // Advance the pipeline unless the final stage and output are both full and the receiver is not ready
  assign en          = !lv_q || !ov_q || out_ready_i;
  assign in_ready_o  = en;
  assign cfg_ready_o = 1'b1;

  // Mass register
  logic [InW-1:0] mass_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mass_q <= MassReset;
    end else if (cfg_valid_i) begin
      mass_q <= mass_i;
    end
  end

  // Stage A: squares and scaled radius
  logic              va_q;
  logic [SqW-1:0]    b2_q, m2_q;
  logic [RadW2-1:0]  rp_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
    end else if (en) begin
      va_q <= in_valid_i;
    end
  end
  always_ff @(posedge clk_i) begin
    if (en) begin
      b2_q <= SqW'(coefficient_b_i) * SqW'(coefficient_b_i);
      m2_q <= SqW'(mass_q) * SqW'(mass_q);
      rp_q <= RadW2'(coefficient_b_i) * RadW2'(TwoOverSqrt3);
    end
  end

  // Stage B: 27 M^2, domain test, rounded radius
  logic [NumW-1:0]  num;
  logic [RadW2:0]   rsum;
  logic             dom_b;
  always_comb begin
    num   = {1'b0, m2_q, 4'b0} + {2'b0, m2_q, 3'b0} + {4'b0, m2_q, 1'b0}
          + {5'b0, m2_q};
    dom_b = (b2_q != '0) && ({5'b0, b2_q} >= num);
    rsum  = {1'b0, rp_q} + (RadW2 + 1)'(64'd536870912);
  end

  logic [QuoW:0]   dv_vld;
  logic [SdW-1:0]  dv_side [0:QuoW];
  logic [SqW-1:0]  dv_den  [0:QuoW];
  logic [SqW-1:0]  dv_rem  [0:QuoW];
  logic [QuoW-1:0] dv_quo  [0:QuoW];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dv_vld[0] <= 1'b0;
    end else if (en) begin
      dv_vld[0] <= va_q;
    end
  end
  always_ff @(posedge clk_i) begin
    if (en) begin
      dv_side[0] <= {dom_b, rsum[RadW2-1:30]};
      dv_den[0]  <= b2_q;
      dv_rem[0]  <= num[SqW-1:0];
      dv_quo[0]  <= '0;
    end
  end

  // Divider chain: 27 M^2 * 2^60 / b^2
  for (genvar i = 0; i < QuoW; i++) begin : g_div
    tcrs_div_cell #(.FIRST((i == 0) ? 1 : 0), .SIDE_W(SdW)) u_cell (
      .clk_i, .rst_ni, .en_i(en),
      .valid_i(dv_vld[i]),   .side_i(dv_side[i]),
      .den_i(dv_den[i]),     .rem_i(dv_rem[i]),     .quo_i(dv_quo[i]),
      .valid_o(dv_vld[i+1]), .side_o(dv_side[i+1]),
      .den_o(dv_den[i+1]),   .rem_o(dv_rem[i+1]),   .quo_o(dv_quo[i+1])
    );
  end

  // First square root chain: c
  logic [RootW:0]   s1_vld;
  logic [SdW-1:0]   s1_side [0:RootW];
  logic [RadW-1:0]  s1_rad  [0:RootW];
  logic [RemW-1:0]  s1_rem  [0:RootW];
  logic [RootW-1:0] s1_root [0:RootW];

  assign s1_vld[0]  = dv_vld[QuoW];
  assign s1_side[0] = dv_side[QuoW];
  assign s1_rad[0]  = {1'b0, dv_quo[QuoW]};
  assign s1_rem[0]  = '0;
  assign s1_root[0] = '0;

  for (genvar i = 0; i < RootW; i++) begin : g_sq1
    tcrs_sqrt_cell #(.SIDE_W(SdW)) u_cell (
      .clk_i, .rst_ni, .en_i(en),
      .valid_i(s1_vld[i]),   .side_i(s1_side[i]),
      .rad_i(s1_rad[i]),     .rem_i(s1_rem[i]),     .root_i(s1_root[i]),
      .valid_o(s1_vld[i+1]), .side_o(s1_side[i+1]),
      .rad_o(s1_rad[i+1]),   .rem_o(s1_rem[i+1]),   .root_o(s1_root[i+1])
    );
  end

  // Stage C: c^2
  logic             vc_q;
  logic [SdW-1:0]   sc_q;
  logic [RootW-1:0] c_q;
  logic [RadW-1:0]  csq_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vc_q <= 1'b0;
    end else if (en) begin
      vc_q <= s1_vld[RootW];
    end
  end
  always_ff @(posedge clk_i) begin
    if (en) begin
      sc_q  <= s1_side[RootW];
      c_q   <= s1_root[RootW];
      csq_q <= RadW'(s1_root[RootW]) * RadW'(s1_root[RootW]);
    end
  end

  // Second square root chain: s = sqrt(1 - c^2)
  logic [RootW:0]   s2_vld;
  logic [ScW-1:0]   s2_side [0:RootW];
  logic [RadW-1:0]  s2_rad  [0:RootW];
  logic [RemW-1:0]  s2_rem  [0:RootW];
  logic [RootW-1:0] s2_root [0:RootW];

  assign s2_vld[0]  = vc_q;
  assign s2_side[0] = {c_q, sc_q};
  assign s2_rad[0]  = (RadW'(64'd1) << 60) - csq_q;
  assign s2_rem[0]  = '0;
  assign s2_root[0] = '0;

  for (genvar i = 0; i < RootW; i++) begin : g_sq2
    tcrs_sqrt_cell #(.SIDE_W(ScW)) u_cell (
      .clk_i, .rst_ni, .en_i(en),
      .valid_i(s2_vld[i]),   .side_i(s2_side[i]),
      .rad_i(s2_rad[i]),     .rem_i(s2_rem[i]),     .root_i(s2_root[i]),
      .valid_o(s2_vld[i+1]), .side_o(s2_side[i+1]),
      .rad_o(s2_rad[i+1]),   .rem_o(s2_rem[i+1]),   .root_o(s2_root[i+1])
    );
  end

  // Vectoring CORDIC chain: z -> acos(c)
  logic [Nst:0]         vx_vld;
  logic [SdW-1:0]       vx_side [0:Nst];
  logic signed [CW-1:0] vx_x [0:Nst];
  logic signed [CW-1:0] vx_y [0:Nst];
  logic signed [CW-1:0] vx_z [0:Nst];

  assign vx_vld[0]  = s2_vld[RootW];
  assign vx_side[0] = s2_side[RootW][SdW-1:0];
  assign vx_x[0]    = $signed({3'b000, s2_side[RootW][ScW-1:SdW]});
  assign vx_y[0]    = $signed({3'b000, s2_root[RootW]});
  assign vx_z[0]    = '0;

  for (genvar i = 0; i < Nst; i++) begin : g_vec
    tcrs_cordic_cell #(.IDX(i), .ROTATE(0), .SIDE_W(SdW)) u_cell (
      .clk_i, .rst_ni, .en_i(en),
      .valid_i(vx_vld[i]),   .side_i(vx_side[i]),
      .x_i(vx_x[i]),         .y_i(vx_y[i]),         .z_i(vx_z[i]),
      .valid_o(vx_vld[i+1]), .side_o(vx_side[i+1]),
      .x_o(vx_x[i+1]),       .y_o(vx_y[i+1]),       .z_o(vx_z[i+1])
    );
  end

  // Stage T: theta = pi - z, clamped, times the reciprocal of three
  logic signed [CW:0] theta_s;
  logic [31:0]        theta_u;
  always_comb begin
    theta_s = $signed({2'b00, PiQ30}) - $signed({vx_z[Nst][CW-1], vx_z[Nst]});
    theta_u = theta_s[CW] ? 32'd0 : theta_s[31:0];
  end

  logic           vt_q;
  logic [SdW-1:0] st_q;
  logic [63:0]    tp_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vt_q <= 1'b0;
    end else if (en) begin
      vt_q <= vx_vld[Nst];
    end
  end
  always_ff @(posedge clk_i) begin
    if (en) begin
      st_q <= vx_side[Nst];
      tp_q <= 64'(theta_u) * 64'(Recip3);
    end
  end

  // Rotation CORDIC chain: cos(phi), sin(phi)
  logic [Nst:0]         rt_vld;
  logic [SdW-1:0]       rt_side [0:Nst];
  logic signed [CW-1:0] rt_x [0:Nst];
  logic signed [CW-1:0] rt_y [0:Nst];
  logic signed [CW-1:0] rt_z [0:Nst];

  assign rt_vld[0]  = vt_q;
  assign rt_side[0] = st_q;
  assign rt_x[0]    = $signed({4'b0000, GainInvQ30});
  assign rt_y[0]    = '0;
  assign rt_z[0]    = $signed({3'b000, tp_q[63:33]});

  for (genvar i = 0; i < Nst; i++) begin : g_rot
    tcrs_cordic_cell #(.IDX(i), .ROTATE(1), .SIDE_W(SdW)) u_cell (
      .clk_i, .rst_ni, .en_i(en),
      .valid_i(rt_vld[i]),   .side_i(rt_side[i]),
      .x_i(rt_x[i]),         .y_i(rt_y[i]),         .z_i(rt_z[i]),
      .valid_o(rt_vld[i+1]), .side_o(rt_side[i+1]),
      .x_o(rt_x[i+1]),       .y_o(rt_y[i+1]),       .z_o(rt_z[i+1])
    );
  end

  // Stage P1: sin * sqrt3/2
  logic                 v1_q;
  logic [SdW-1:0]       s1p_q;
  logic signed [CW-1:0] x1_q;
  logic signed [HpW-1:0] hp_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else if (en) begin
      v1_q <= rt_vld[Nst];
    end
  end
  always_ff @(posedge clk_i) begin
    if (en) begin
      s1p_q <= rt_side[Nst];
      x1_q  <= rt_x[Nst];
      hp_q  <= HpW'(rt_y[Nst]) * $signed(HpW'({1'b0, HalfSqrt3Q30}));
    end
  end

  // Stage P2: the three cosine terms
  logic signed [HpW-1:0]  sy_full;
  logic signed [CosW-1:0] sy, half_e;
  logic signed [CW-1:0]   half;
  always_comb begin
    sy_full = (hp_q + HpW'(HalfUlp)) >>> 30;
    sy      = sy_full[CosW-1:0];
    half    = x1_q >>> 1;
    half_e  = {{(CosW-CW){half[CW-1]}}, half};
  end

  logic                   v2_q;
  logic [SdW-1:0]         s2p_q;
  logic signed [CosW-1:0] cos_q [0:2];
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
    end else if (en) begin
      v2_q <= v1_q;
    end
  end
  always_ff @(posedge clk_i) begin
    if (en) begin
      s2p_q    <= s1p_q;
      cos_q[0] <= {{(CosW-CW){x1_q[CW-1]}}, x1_q};
      cos_q[1] <= sy - half_e;
      cos_q[2] <= -half_e - sy;
    end
  end

  // Stage P3: radius times each cosine
  logic                  v3_q, d3_q;
  logic signed [PrW-1:0] pr_q [0:2];
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v3_q <= 1'b0;
    end else if (en) begin
      v3_q <= v2_q;
    end
  end
  always_ff @(posedge clk_i) begin
    if (en) begin
      d3_q <= s2p_q[SdW-1];
      for (int k = 0; k < 3; k++) begin
        pr_q[k] <= $signed(PrW'({1'b0, s2p_q[RW-1:0]})) * PrW'(cos_q[k]);
      end
    end
  end

  // Stage P4: round, saturate, pick the largest, zero when out of domain
  logic signed [PrW-1:0]  rnd [0:2];
  logic signed [OutW-1:0] sat [0:2];
  logic signed [OutW-1:0] best01, best;
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      rnd[k] = (pr_q[k] + HalfUlp) >>> 30;
      if (rnd[k] > OutMax) begin
        sat[k] = OutMax[OutW-1:0];
      end else if (rnd[k] < OutMin) begin
        sat[k] = OutMin[OutW-1:0];
      end else begin
        sat[k] = rnd[k][OutW-1:0];
      end
    end
    best01 = (sat[1] > sat[0]) ? sat[1] : sat[0];
    best   = (sat[2] > best01) ? sat[2] : best01;
  end

  logic                   d4_q;
  logic signed [OutW-1:0] r4_q [0:2];
  logic signed [OutW-1:0] b4_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lv_q <= 1'b0;
    end else if (en) begin
      lv_q <= v3_q;
    end
  end
  always_ff @(posedge clk_i) begin
    if (en) begin
      d4_q <= d3_q;
      for (int k = 0; k < 3; k++) begin
        r4_q[k] <= d3_q ? sat[k] : '0;
      end
      b4_q <= d3_q ? best : '0;
    end
  end

  // Output register: load when empty or when the receiver takes the transfer
  logic                   od_q;
  logic signed [OutW-1:0] o0_q, o1_q, o2_q, ob_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ov_q <= 1'b0;
    end else if (!ov_q || out_ready_i) begin
      ov_q <= lv_q;
    end
  end
  always_ff @(posedge clk_i) begin
    if (!ov_q || out_ready_i) begin
      od_q <= d4_q;
      o0_q <= r4_q[0];
      o1_q <= r4_q[1];
      o2_q <= r4_q[2];
      ob_q <= b4_q;
    end
  end

  assign out_valid_o    = ov_q;
  assign root_first_o   = o0_q;
  assign root_second_o  = o1_q;
  assign root_third_o   = o2_q;
  assign largest_root_o = ob_q;
  assign in_domain_o    = od_q;

endmodule

### hdl/tcrs_checker.sv
module tcrs_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               out_valid_o,
  input logic               out_ready_i,
  input logic signed [26:0] root_first_o,
  input logic signed [26:0] root_second_o,
  input logic signed [26:0] root_third_o,
  input logic signed [26:0] largest_root_o,
  input logic               in_domain_o
);

  // Out of domain results carry zeros
  a_zero_out_of_domain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !in_domain_o |-> root_first_o == 0 && root_second_o == 0 &&
      root_third_o == 0 && largest_root_o == 0)
    else $error("out of domain transfer with nonzero roots");

  // Largest root bounds all three
  a_largest_bounds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> largest_root_o >= root_first_o &&
      largest_root_o >= root_second_o && largest_root_o >= root_third_o)
    else $error("largest root below one of the roots");

  // Largest root is one of the three
  a_largest_member: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> largest_root_o == root_first_o ||
      largest_root_o == root_second_o || largest_root_o == root_third_o)
    else $error("largest root matches no root");

  // A stalled result stays valid with the same largest root
  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(largest_root_o))
    else $error("stalled transfer dropped or changed");

endmodule

bind trig_cubic_root_solver tcrs_checker u_tcrs_checker (.*);

### tb/sv/tcrs_checker.sv
`timescale 1ns / 1ps

module tcrs_scoreboard import tcrs_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_valid_i,
  input  logic                   cfg_ready_i,
  input  logic [InW-1:0]         mass_i,
  input  logic                   in_valid_i,
  input  logic                   in_ready_i,
  input  logic [InW-1:0]         coefficient_b_i,
  input  logic                   out_valid_i,
  input  logic                   out_ready_i,
  input  logic signed [OutW-1:0] root_first_i,
  input  logic signed [OutW-1:0] root_second_i,
  input  logic signed [OutW-1:0] root_third_i,
  input  logic signed [OutW-1:0] largest_root_i,
  input  logic                   in_domain_i,
  output int                     fail_count_o,
  output int                     roots_pending_o
);

  typedef struct packed {
    logic signed [OutW-1:0] first;
    logic signed [OutW-1:0] second;
    logic signed [OutW-1:0] third;
    logic signed [OutW-1:0] largest;
    logic                   domain;
  } roots_t;

  localparam int Stages = (CordicStagesDef < AtanLen) ? CordicStagesDef : AtanLen;

  longint angle_step [AtanLen] = '{
    64'h3243F6A8, 64'h1DAC6705, 64'h0FADBAFC, 64'h07F56EA6, 64'h03FEAB76, 64'h01FFD55B,
    64'h00FFFAAA, 64'h007FFF55, 64'h003FFFEA, 64'h001FFFFD, 64'h000FFFFF, 64'h0007FFFF,
    64'h0003FFFF, 64'h0001FFFF, 64'h0000FFFF, 64'h00007FFF, 64'h00003FFF, 64'h00001FFF,
    64'h00000FFF, 64'h000007FF, 64'h000003FF, 64'h000001FF, 64'h000000FF, 64'h0000007F,
    64'h0000003F, 64'h0000001F, 64'h0000000F, 64'h00000008, 64'h00000004, 64'h00000002,
    64'h00000001, 64'h00000000
  };

  logic [InW-1:0] mass_q;
  roots_t         roots_q [$];

  // Integer square root, 31 result bits
  function automatic longint unsigned isqrt(input longint unsigned v);
    longint unsigned r, t;
    r = 0;
    for (int i = 30; i >= 0; i--) begin
      t = r | (64'd1 << i);
      if (t * t <= v) r = t;
    end
    return r;
  endfunction

  function automatic longint clamp_root(input longint v);
    if (v > 64'sd67108863) return 64'sd67108863;
    if (v < -64'sd67108864) return -64'sd67108864;
    return v;
  endfunction

  // Solve one coefficient against the current mass
  function automatic roots_t solve_cubic(input logic [InW-1:0] b_in, input logic [InW-1:0] m);
    longint unsigned b, num, den, q, rem, c, s, r;
    longint x, y, z, xs, ys, theta, phi, half, sy, rt [3], best;
    longint ck [3];
    roots_t res;
    b = b_in;
    num = 64'd27 * m * m;
    den = b * b;
    res = '0;
    if (b == 0 || den < num) return res;
    // Q60 ratio by restoring division
    q = (num >= den) ? 1 : 0;
    rem = num - (q != 0 ? den : 0);
    for (int i = 0; i < 60; i++) begin
      rem = rem << 1;
      q = q << 1;
      if (rem >= den) begin
        rem = rem - den;
        q = q | 1;
      end
    end
    c = isqrt(q);
    s = isqrt((64'd1 << 60) - c * c);
    // Vectoring: z converges to acos(c)
    x = c; y = s; z = 0;
    for (int i = 0; i < Stages; i++) begin
      xs = x >>> i; ys = y >>> i;
      if (y >= 0) begin
        x += ys; y -= xs; z += angle_step[i];
      end else begin
        x -= ys; y += xs; z -= angle_step[i];
      end
    end
    theta = longint'(PiQ30) - z;
    if (theta < 0) theta = 0;
    phi = theta / 3;
    // Rotation: x -> cos(phi), y -> sin(phi)
    x = longint'(GainInvQ30); y = 0; z = phi;
    for (int i = 0; i < Stages; i++) begin
      xs = x >>> i; ys = y >>> i;
      if (z >= 0) begin
        x -= ys; y += xs; z -= angle_step[i];
      end else begin
        x += ys; y -= xs; z += angle_step[i];
      end
    end
    half = x >>> 1;
    sy = (y * longint'(HalfSqrt3Q30) + (64'sd1 << 29)) >>> 30;
    ck[0] = x;
    ck[1] = -half + sy;
    ck[2] = -half - sy;
    r = (b * longint'(TwoOverSqrt3) + (64'd1 << 29)) >> 30;
    for (int k = 0; k < 3; k++)
      rt[k] = clamp_root((longint'(r) * ck[k] + (64'sd1 << 29)) >>> 30);
    best = rt[0];
    for (int k = 1; k < 3; k++)
      if (rt[k] > best) best = rt[k];
    res.first   = rt[0][OutW-1:0];
    res.second  = rt[1][OutW-1:0];
    res.third   = rt[2][OutW-1:0];
    res.largest = best[OutW-1:0];
    res.domain  = 1'b1;
    return res;
  endfunction

  assign roots_pending_o = roots_q.size();

  // Track the register, predict on input transfers, compare on output transfers
  always @(posedge clk_i or negedge rst_ni) begin
    roots_t want;
    if (!rst_ni) begin
      mass_q = MassReset;
      roots_q.delete();
      fail_count_o = 0;
    end else begin
      if (in_valid_i && in_ready_i) roots_q.push_back(solve_cubic(coefficient_b_i, mass_q));
      if (cfg_valid_i && cfg_ready_i) mass_q = mass_i;
      if (out_valid_i && out_ready_i) begin
        if (roots_q.size() == 0) begin
          $display("%0t: unexpected result %h", $time,
                   {root_first_i, root_second_i, root_third_i, largest_root_i, in_domain_i});
          fail_count_o++;
        end else begin
          want = roots_q.pop_front();
          if (root_first_i !== want.first) begin
            $display("%0t: root_first expected %0d actual %0d", $time, want.first, root_first_i);
            fail_count_o++;
          end
          if (root_second_i !== want.second) begin
            $display("%0t: root_second expected %0d actual %0d", $time, want.second,
                     root_second_i);
            fail_count_o++;
          end
          if (root_third_i !== want.third) begin
            $display("%0t: root_third expected %0d actual %0d", $time, want.third, root_third_i);
            fail_count_o++;
          end
          if (largest_root_i !== want.largest) begin
            $display("%0t: largest_root expected %0d actual %0d", $time, want.largest,
                     largest_root_i);
            fail_count_o++;
          end
          if (in_domain_i !== want.domain) begin
            $display("%0t: in_domain expected %0d actual %0d", $time, want.domain, in_domain_i);
            fail_count_o++;
          end
        end
      end
    end
  end

endmodule

### tb/sv/tb_trig_cubic_root_solver.sv
`timescale 1ns / 1ps

module tb_trig_cubic_root_solver;
  import tcrs_pkg::*;

  localparam logic [InW-1:0] BMax = {InW{1'b1}};
  localparam int Drain = 200;

  logic clk, rst_n;
  logic cfg_valid, cfg_ready, in_valid, in_ready, out_valid, out_ready, in_domain;
  logic [InW-1:0] mass, coef_b;
  logic signed [OutW-1:0] root_a, root_b, root_c, root_max;
  int fail_count, roots_pending, sent_count;
  logic quiet_run;

  trig_cubic_root_solver u_dut (
    .clk_i(clk), .rst_ni(rst_n),
    .cfg_valid_i(cfg_valid), .cfg_ready_o(cfg_ready), .mass_i(mass),
    .in_valid_i(in_valid), .in_ready_o(in_ready), .coefficient_b_i(coef_b),
    .out_valid_o(out_valid), .out_ready_i(out_ready),
    .root_first_o(root_a), .root_second_o(root_b), .root_third_o(root_c),
    .largest_root_o(root_max), .in_domain_o(in_domain)
  );

  tcrs_scoreboard u_checker (
    .clk_i(clk), .rst_ni(rst_n),
    .cfg_valid_i(cfg_valid), .cfg_ready_i(cfg_ready), .mass_i(mass),
    .in_valid_i(in_valid), .in_ready_i(in_ready), .coefficient_b_i(coef_b),
    .out_valid_i(out_valid), .out_ready_i(out_ready),
    .root_first_i(root_a), .root_second_i(root_b), .root_third_i(root_c),
    .largest_root_i(root_max), .in_domain_i(in_domain),
    .fail_count_o(fail_count), .roots_pending_o(roots_pending)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #2ms;
    $display("tb_trig_cubic_root_solver NOT OK");
    $finish;
  end

  // Offer one coefficient, with an occasional idle burst before it
  task automatic send_coef(input logic [InW-1:0] b);
    if (!quiet_run && $urandom_range(0, 7) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(negedge clk);
    end
    in_valid <= 1'b1;
    coef_b   <= b;
    do @(posedge clk); while (!in_ready);
    sent_count++;
    @(negedge clk);
  endtask

  // Drain the pipeline, then write the mass register
  task automatic write_mass(input logic [InW-1:0] m);
    in_valid <= 1'b0;
    wait (roots_pending == 0);
    repeat (Drain) @(negedge clk);
    cfg_valid <= 1'b1;
    mass      <= m;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Coefficient biased toward the real-root domain of mass m
  function automatic logic [InW-1:0] pick_coef(input logic [InW-1:0] m);
    longint unsigned lo;
    lo = (longint'(m) * 5197) / 1000 + 1;
    if ($urandom_range(0, 9) < 7 && lo <= BMax) return InW'($urandom_range(32'(BMax), 32'(lo)));
    return InW'($urandom() & 32'(BMax));
  endfunction

  // Receiver: ready at first, one long hold-off, idle bursts, then always ready
  initial begin
    out_ready = 1'b1;
    wait (rst_n && sent_count >= 40);
    @(negedge clk);
    out_ready <= 1'b0;
    repeat (600) @(negedge clk);
    while (!quiet_run) begin
      out_ready <= ($urandom_range(0, 2) != 0);
      repeat ($urandom_range(1, 16)) @(negedge clk);
    end
    out_ready <= 1'b1;
  end

  initial begin
    logic [InW-1:0] mass_set [6];
    rst_n = 1'b0;
    cfg_valid = 1'b0;
    in_valid = 1'b0;
    mass = '0;
    coef_b = '0;
    sent_count = 0;
    quiet_run = 1'b0;
    repeat (6) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // Directed: extremes and the domain edge at the reset mass of one
    send_coef('0);
    send_coef(25'd1);
    send_coef(BMax);
    send_coef(25'd340535);
    send_coef(25'd340536);
    send_coef(25'd65536);
    send_coef(25'h0AAAAAA);
    send_coef(25'h1555555);
    write_mass('0);
    send_coef('0);
    send_coef(25'd1);
    send_coef(BMax);
    send_coef(25'd65536);
    write_mass(BMax);
    send_coef(BMax);
    send_coef('0);
    write_mass(25'd1);
    send_coef(25'd5);
    send_coef(25'd6);
    send_coef(BMax);

    // Random phases across several mass settings; the first is long enough to fill the pipe
    mass_set = '{25'd65536, 25'd0, BMax, 25'd1, 25'($urandom_range(1, 400000)),
                 25'($urandom_range(400000, 6000000))};
    foreach (mass_set[p]) begin
      write_mass(mass_set[p]);
      if (p == 5) quiet_run = 1'b1;
      repeat ((p == 0) ? 250 : 60) send_coef(pick_coef(mass_set[p]));
    end
    in_valid <= 1'b0;

    wait (roots_pending == 0);
    repeat (Drain) @(negedge clk);
    if (fail_count == 0) begin
      $display("tb_trig_cubic_root_solver OK");
    end else begin
      $display("tb_trig_cubic_root_solver NOT OK");
    end
    $finish;
  end

endmodule
